// ----- src/stle_pkg.sv -----
// package for the software timer list engine
// holds sizes, function codes and status codes; no dependencies
package stle_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int ID_W       = 4;
    localparam int TICK_W     = 32;

    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_CANCEL   = 2'd1;
    localparam logic [1:0] FUNC_TICK     = 2'd2;
    localparam logic [1:0] FUNC_SET      = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PARAM = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BUSY      = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic              fired;
        logic [ID_W-1:0]   fired_id;
        logic [TICK_W-1:0] tick_count;
    } result_t;

endpackage

// ----- src/software_timer_list_engine_core.sv -----
// top level of the software timer list engine
// uses stle_pkg and two stle_ram instances (list order and remaining ticks)
//
// A bank of one-shot countdown timers. Each input transfer carries a function
// code in s_tuser: register, cancel, tick or set tick count. Register, cancel
// and set give one result; a tick gives one result per expired timer, front of
// the list (most recently registered) first, with m_tlast on the final one.
// Register and set go from the accepting state straight to the report state.
// Cancel and a running tick walk the list, because each entry needs an order
// read, a dependent remaining-ticks read and a write back through the two rams
// with registered read data; the results follow the walk (one for a cancel or
// a tick with no expiry, one per expired timer otherwise).
// One item is in work at a time; a new item is taken as soon as the engine
// is back in idle, even while the previous result still waits on m_tready.
// The list is stored back to front: the front of the list sits at the
// highest occupied ram entry.
module software_timer_list_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    // config: os_running
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // timer_id[3:0], delay_ticks[35:4], load_tick[67:36], zero
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], fired[2], fired_id[6:3], tick_count[38:7], zero
    output logic        m_tlast
);
    localparam int IDX_W  = stle_pkg::IDX_W;
    localparam int CNT_W  = stle_pkg::CNT_W;
    localparam int NUM    = stle_pkg::NUM_TIMERS;
    localparam int TICK_W = stle_pkg::TICK_W;
    localparam int ID_W   = stle_pkg::ID_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDO  = 3'd1;   // issue order read
    localparam logic [2:0] S_RDR  = 3'd2;   // take handle, issue remaining read
    localparam logic [2:0] S_UPD  = 3'd3;   // modify and write back
    localparam logic [2:0] S_RESP = 3'd4;   // single result
    localparam logic [2:0] S_EMIT = 3'd5;   // fired results

    logic [2:0]        state_reg, state_next;
    logic              running_reg;
    logic [NUM-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;
    logic [CNT_W-1:0]  nexp_reg, nexp_next;
    logic [TICK_W-1:0] sys_reg, sys_next;
    logic              is_tick_reg, is_tick_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [IDX_W-1:0]  h_reg, h_next;
    logic [1:0]        st_reg, st_next;
    logic [IDX_W-1:0]  stack_reg [NUM];

    logic              m_valid_reg, m_valid_next;
    stle_pkg::result_t res_reg, res_next;
    logic              last_reg, last_next;

    // ram ports
    logic              ord_we, rem_we;
    logic [IDX_W-1:0]  ord_waddr, ord_raddr, rem_waddr, rem_raddr;
    logic [IDX_W-1:0]  ord_wdata, ord_rdata;
    logic [TICK_W-1:0] rem_wdata, rem_rdata;

    logic [ID_W-1:0]   in_id;
    logic [TICK_W-1:0] in_delay, in_time;
    logic [IDX_W-1:0]  in_addr;
    logic              in_range, in_active, accept, out_free;
    logic [TICK_W-1:0] dec;
    logic              push;

    assign in_id     = s_tdata[3:0];
    assign in_delay  = s_tdata[35:4];
    assign in_time   = s_tdata[67:36];
    assign in_addr   = IDX_W'(in_id);
    assign in_range  = 32'(in_id) < 32'(NUM);
    assign in_active = in_range && active_reg[in_addr];
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign dec       = rem_rdata - TICK_W'(1);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, res_reg.tick_count, res_reg.fired_id, res_reg.fired, res_reg.status};
    assign m_tlast   = last_reg;

    stle_ram #(.WIDTH(IDX_W), .DEPTH(NUM)) u_order (
        .aclk(aclk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    stle_ram #(.WIDTH(TICK_W), .DEPTH(NUM)) u_remain (
        .aclk(aclk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
        .raddr(rem_raddr), .rdata(rem_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        active_next  = active_reg;
        len_next     = len_reg;
        i_next       = i_reg;
        keep_next    = keep_reg;
        nexp_next    = nexp_reg;
        sys_next     = sys_reg;
        is_tick_next = is_tick_reg;
        id_next      = id_reg;
        h_next       = h_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg && !m_tready;
        res_next     = res_reg;
        last_next    = last_reg;
        push         = 1'b0;
        ord_we       = 1'b0;
        ord_waddr    = keep_reg[IDX_W-1:0];
        ord_wdata    = h_reg;
        ord_raddr    = i_reg[IDX_W-1:0];
        rem_we       = 1'b0;
        rem_waddr    = h_reg;
        rem_wdata    = dec;
        rem_raddr    = h_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    id_next   = in_id;
                    i_next    = '0;
                    keep_next = '0;
                    nexp_next = '0;
                    st_next   = stle_pkg::ST_OK;
                    state_next = S_RESP;
                    case (s_tuser)
                        stle_pkg::FUNC_REGISTER: begin
                            if (in_delay == '0 || !in_range) begin
                                st_next = stle_pkg::ST_BAD_PARAM;
                            end else if (active_reg[in_addr]) begin
                                st_next = stle_pkg::ST_BUSY;
                            end else begin
                                // append at the physical top, which is the list front
                                ord_we    = 1'b1;
                                ord_waddr = len_reg[IDX_W-1:0];
                                ord_wdata = in_addr;
                                rem_we    = 1'b1;
                                rem_waddr = in_addr;
                                rem_wdata = in_delay;
                                len_next  = len_reg + CNT_W'(1);
                                active_next[in_addr] = 1'b1;
                            end
                        end
                        stle_pkg::FUNC_CANCEL: begin
                            if (!in_active) begin
                                st_next = stle_pkg::ST_NOT_FOUND;
                            end else begin
                                is_tick_next = 1'b0;
                                state_next   = S_RDO;
                            end
                        end
                        stle_pkg::FUNC_TICK: begin
                            if (running_reg) begin
                                sys_next     = sys_reg + TICK_W'(1);
                                is_tick_next = 1'b1;
                                state_next   = S_RDO;
                            end
                        end
                        default: begin
                            sys_next = in_time;
                        end
                    endcase
                end
            end
            S_RDO: begin
                if (i_reg == len_reg) begin
                    len_next = keep_reg;
                    state_next = (is_tick_reg && nexp_reg != '0) ? S_EMIT : S_RESP;
                end else begin
                    state_next = S_RDR;
                end
            end
            S_RDR: begin
                h_next     = ord_rdata;
                rem_raddr  = ord_rdata;
                state_next = S_UPD;
            end
            S_UPD: begin
                if (is_tick_reg) begin
                    rem_we = 1'b1;
                    if (dec == '0) begin
                        active_next[h_reg] = 1'b0;
                        push      = 1'b1;
                        nexp_next = nexp_reg + CNT_W'(1);
                    end else begin
                        ord_we    = 1'b1;
                        keep_next = keep_reg + CNT_W'(1);
                    end
                end else if (ID_W'(h_reg) == id_reg) begin
                    active_next[h_reg] = 1'b0;
                end else begin
                    ord_we    = 1'b1;
                    keep_next = keep_reg + CNT_W'(1);
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = S_RDO;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    res_next.status     = st_reg;
                    res_next.fired      = 1'b0;
                    res_next.fired_id   = '0;
                    res_next.tick_count = sys_reg;
                    last_next           = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_EMIT: begin
                // expired timers were gathered back to front; pop to report front first
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    res_next.status     = stle_pkg::ST_OK;
                    res_next.fired      = 1'b1;
                    res_next.fired_id   = ID_W'(stack_reg[IDX_W'(nexp_reg - CNT_W'(1))]);
                    res_next.tick_count = sys_reg;
                    last_next           = (nexp_reg == CNT_W'(1));
                    nexp_next           = nexp_reg - CNT_W'(1);
                    if (nexp_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            running_reg <= 1'b0;
            active_reg  <= '0;
            len_reg     <= '0;
            sys_reg     <= '0;
            m_valid_reg <= 1'b0;
            nexp_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            len_reg     <= len_next;
            sys_reg     <= sys_next;
            m_valid_reg <= m_valid_next;
            nexp_reg    <= nexp_next;
            if (cfg_valid && cfg_ready) begin
                running_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        keep_reg    <= keep_next;
        is_tick_reg <= is_tick_next;
        id_reg      <= id_next;
        h_reg       <= h_next;
        st_reg      <= st_next;
        res_reg     <= res_next;
        last_reg    <= last_next;
        if (push) begin
            stack_reg[nexp_reg[IDX_W-1:0]] <= h_reg;
        end
    end
endmodule

// ----- src/stle_ram.sv -----
// generic single-port-write, one-read ram with registered read data
// no dependencies
module stle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/stle_checker.sv -----
// port-level checks for the software timer list engine
// bound to software_timer_list_engine_core; no package use
module stle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    // a result waiting on the sink stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an expiry report always carries ok status
    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd0)
        else $error("fired result with bad status");

    a_idle_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[6:3] == 4'd0)
        else $error("handle shown without expiry");
endmodule

bind software_timer_list_engine_core stle_checker u_stle_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
);
